@@ rtl/sfa_pkg.sv @@
`default_nettype none

package sfa_pkg;

   // frame and stack geometry
   localparam int FRAME_WIDTH     = 44;
   localparam int STACK_DEPTH     = 256;
   localparam int COUNT_WIDTH     = $clog2(STACK_DEPTH + 1);
   localparam int GROUP_SIZE      = 16;
   localparam int GROUP_COUNT     = (STACK_DEPTH + GROUP_SIZE - 1) / GROUP_SIZE;
   localparam int STATUS_WIDTH    = 3;
   localparam int REQ_DATA_WIDTH  = ((FRAME_WIDTH + 7) / 8) * 8;
   localparam int RSP_DATA_WIDTH  = ((FRAME_WIDTH + STATUS_WIDTH + 7) / 8) * 8;
   localparam int CSR_INDEX_WIDTH = 1;

   // request kinds
   localparam logic ACTION_ALLOC = 1'b0;
   localparam logic ACTION_FREE  = 1'b1;

   // register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FIRST_FRAME = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_END_FRAME   = 1'b1;

   typedef enum logic [STATUS_WIDTH-1:0] {
      STATUS_ALLOCATED       = 3'd0,
      STATUS_EXHAUSTED       = 3'd1,
      STATUS_FREED           = 3'd2,
      STATUS_NEVER_ALLOCATED = 3'd3,
      STATUS_ALREADY_FREE    = 3'd4,
      STATUS_STACK_FULL      = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      STACK_HOLD,
      STACK_PUSH,
      STACK_POP
   } stack_op_type;

   // command broadcast to every cell of the row
   typedef struct packed {
      stack_op_type           op;
      logic [FRAME_WIDTH-1:0] push_frame;
   } stack_cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_REDUCE,
      ST_DECIDE
   } alloc_state_type;

endpackage

`default_nettype wire

@@ rtl/sfa_cell.sv @@
`default_nettype none

module sfa_cell (
   input  wire logic                           clock,
   input  wire sfa_pkg::stack_cmd_type         cmd,
   input  wire logic [sfa_pkg::FRAME_WIDTH-1:0] prev_value,
   input  wire logic [sfa_pkg::FRAME_WIDTH-1:0] next_value,
   input  wire logic                           cell_valid,
   input  wire logic [sfa_pkg::FRAME_WIDTH-1:0] probe,
   output logic      [sfa_pkg::FRAME_WIDTH-1:0] value_ff,
   output logic                                hit_ff
);

   logic [sfa_pkg::FRAME_WIDTH-1:0] value_in;

   // shift toward the bottom on push, toward the top on pop
   always_comb begin
      unique case (cmd.op)
         sfa_pkg::STACK_PUSH: value_in = prev_value;
         sfa_pkg::STACK_POP:  value_in = next_value;
         sfa_pkg::STACK_HOLD: value_in = value_ff;
         default:             value_in = value_ff;
      endcase
   end

   // entry and registered match against the probed frame
   always_ff @(posedge clock) begin
      value_ff <= value_in;
      hit_ff   <= cell_valid && (value_ff == probe);
   end

endmodule

`default_nettype wire

@@ rtl/sfa_cell_row.sv @@
`default_nettype none

module sfa_cell_row (
   input  wire logic                           clock,
   input  wire sfa_pkg::stack_cmd_type         cmd,
   input  wire logic [sfa_pkg::COUNT_WIDTH-1:0] count,
   input  wire logic [sfa_pkg::FRAME_WIDTH-1:0] probe,
   output logic      [sfa_pkg::FRAME_WIDTH-1:0] top_value,
   output logic                                any_hit
);

   logic [sfa_pkg::FRAME_WIDTH-1:0] cell_value [sfa_pkg::STACK_DEPTH];
   logic [sfa_pkg::STACK_DEPTH-1:0] cell_hit;
   logic [sfa_pkg::GROUP_COUNT-1:0] group_hit_ff;
   logic [sfa_pkg::GROUP_COUNT-1:0] group_hit_in;

   // row of cells, top of stack in cell zero
   for (genvar i = 0; i < sfa_pkg::STACK_DEPTH; i++) begin : g_cell
      logic [sfa_pkg::FRAME_WIDTH-1:0] left_value;
      logic [sfa_pkg::FRAME_WIDTH-1:0] right_value;
      logic                            occupied;

      if (i == 0) begin : g_first
         assign left_value = cmd.push_frame;
      end else begin : g_inner
         assign left_value = cell_value[i-1];
      end

      if (i == sfa_pkg::STACK_DEPTH - 1) begin : g_last
         assign right_value = '0;
      end else begin : g_mid
         assign right_value = cell_value[i+1];
      end

      assign occupied = (sfa_pkg::COUNT_WIDTH'(i) < count);

      sfa_cell u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .prev_value (left_value),
         .next_value (right_value),
         .cell_valid (occupied),
         .probe      (probe),
         .value_ff   (cell_value[i]),
         .hit_ff     (cell_hit[i])
      );
   end

   // first level of the match tree, one or per group of cells
   always_comb begin
      group_hit_in = '0;
      for (int g = 0; g < sfa_pkg::GROUP_COUNT; g++) begin
         for (int j = 0; j < sfa_pkg::GROUP_SIZE; j++) begin
            if (g * sfa_pkg::GROUP_SIZE + j < sfa_pkg::STACK_DEPTH) begin
               group_hit_in[g] = group_hit_in[g] | cell_hit[g * sfa_pkg::GROUP_SIZE + j];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      group_hit_ff <= group_hit_in;
   end

   assign any_hit   = |group_hit_ff;
   assign top_value = cell_value[0];

endmodule

`default_nettype wire

@@ rtl/stack_frame_allocator.sv @@
// order: a taken request passes scan, reduce and decide (held while a result
//    word is unread) for the registered duplicate compare across the cell row
//    and its two-level match tree; a new request is taken only back in idle
// reset: synchronous; stack empty, bump pointer and both registers zero,
//    no clearing pass, stack entries are undefined until pushed
`default_nettype none

module stack_frame_allocator (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // request: tdata = frame_number; tuser = action
   input  wire logic                                  req_tvalid,
   output logic                                       req_tready,
   input  wire logic [sfa_pkg::REQ_DATA_WIDTH-1:0]    req_tdata,
   input  wire logic                                  req_tuser,
   // response: tdata = given_frame, status
   output logic                                       rsp_tvalid,
   input  wire logic                                  rsp_tready,
   output logic      [sfa_pkg::RSP_DATA_WIDTH-1:0]    rsp_tdata,
   // register writes
   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic [sfa_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  wire logic [sfa_pkg::FRAME_WIDTH-1:0]       csr_data
);

   sfa_pkg::alloc_state_type           state_ff, state_in;
   logic [sfa_pkg::COUNT_WIDTH-1:0]    count_ff, count_in;
   logic [sfa_pkg::FRAME_WIDTH-1:0]    next_unused_ff, next_unused_in;
   logic [sfa_pkg::FRAME_WIDTH-1:0]    end_frame_ff;
   logic                               req_action_ff;
   logic [sfa_pkg::FRAME_WIDTH-1:0]    req_frame_ff;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [sfa_pkg::FRAME_WIDTH-1:0]    rsp_frame_ff, rsp_frame_in;
   sfa_pkg::status_type                rsp_status_ff, rsp_status_in;

   sfa_pkg::stack_cmd_type             stack_cmd;
   logic [sfa_pkg::FRAME_WIDTH-1:0]    top_value;
   logic                               any_hit;
   logic                               req_take;
   logic                               rsp_free;
   logic                               decide_go;
   logic                               csr_take;

   assign req_tready = (state_ff == sfa_pkg::ST_IDLE);
   assign req_take   = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign decide_go  = (state_ff == sfa_pkg::ST_DECIDE) && rsp_free;
   assign csr_ready  = 1'b1;
   assign csr_take   = csr_valid && csr_ready;

   sfa_cell_row u_row (
      .clock     (clock),
      .cmd       (stack_cmd),
      .count     (count_ff),
      .probe     (req_frame_ff),
      .top_value (top_value),
      .any_hit   (any_hit)
   );

   // next state
   always_comb begin
      unique case (state_ff)
         sfa_pkg::ST_IDLE:   state_in = req_take ? sfa_pkg::ST_SCAN : sfa_pkg::ST_IDLE;
         sfa_pkg::ST_SCAN:   state_in = sfa_pkg::ST_REDUCE;
         sfa_pkg::ST_REDUCE: state_in = sfa_pkg::ST_DECIDE;
         sfa_pkg::ST_DECIDE: state_in = rsp_free ? sfa_pkg::ST_IDLE : sfa_pkg::ST_DECIDE;
         default:            state_in = sfa_pkg::ST_IDLE;
      endcase
   end

   // decision, stack command and result word
   always_comb begin
      stack_cmd.op         = sfa_pkg::STACK_HOLD;
      stack_cmd.push_frame = req_frame_ff;
      count_in             = count_ff;
      next_unused_in       = next_unused_ff;
      rsp_valid_in         = rsp_valid_ff && !rsp_tready;
      rsp_frame_in         = rsp_frame_ff;
      rsp_status_in        = rsp_status_ff;

      if (decide_go) begin
         rsp_valid_in = 1'b1;
         rsp_frame_in = '0;
         if (req_action_ff == sfa_pkg::ACTION_ALLOC) begin
            priority if (count_ff != '0) begin
               stack_cmd.op  = sfa_pkg::STACK_POP;
               count_in      = count_ff - 1'b1;
               rsp_frame_in  = top_value;
               rsp_status_in = sfa_pkg::STATUS_ALLOCATED;
            end else if (next_unused_ff >= end_frame_ff) begin
               rsp_status_in = sfa_pkg::STATUS_EXHAUSTED;
            end else begin
               next_unused_in = next_unused_ff + 1'b1;
               rsp_frame_in   = next_unused_ff;
               rsp_status_in  = sfa_pkg::STATUS_ALLOCATED;
            end
         end else begin
            priority if (req_frame_ff >= next_unused_ff) begin
               rsp_status_in = sfa_pkg::STATUS_NEVER_ALLOCATED;
            end else if (any_hit) begin
               rsp_status_in = sfa_pkg::STATUS_ALREADY_FREE;
            end else if (count_ff == sfa_pkg::COUNT_WIDTH'(sfa_pkg::STACK_DEPTH)) begin
               rsp_status_in = sfa_pkg::STATUS_STACK_FULL;
            end else begin
               stack_cmd.op  = sfa_pkg::STACK_PUSH;
               count_in      = count_ff + 1'b1;
               rsp_status_in = sfa_pkg::STATUS_FREED;
            end
         end
      end

      // first-frame write reloads the pointer and empties the stack
      if (csr_take && csr_index == sfa_pkg::CSR_FIRST_FRAME) begin
         next_unused_in = csr_data;
         count_in       = '0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= sfa_pkg::ST_IDLE;
         count_ff       <= '0;
         next_unused_ff <= '0;
         end_frame_ff   <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         count_ff       <= count_in;
         next_unused_ff <= next_unused_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (csr_take && csr_index == sfa_pkg::CSR_END_FRAME) begin
            end_frame_ff <= csr_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         req_action_ff <= req_tuser;
         req_frame_ff  <= req_tdata[sfa_pkg::FRAME_WIDTH-1:0];
      end
      rsp_frame_ff  <= rsp_frame_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = sfa_pkg::RSP_DATA_WIDTH'({rsp_status_ff, rsp_frame_ff});

endmodule

`default_nettype wire
